>>> rtl/kdsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdsl_pkg
// Shared types and constants for the multi-key debouncer with short and
// long press detection.
// ----------------------------------------------------------------------------
package kdsl_pkg;

    localparam int PIN_W   = 8;   // pin and event word width
    localparam int CNT_W   = 16;  // per-key hold counter width
    localparam int DEB_W   = 8;   // debounce threshold width
    localparam int CFG_W   = 16;  // widest config register
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS     = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_LONG     = 2'd3
    } phase_t;

    // per-key findings for one tick
    typedef struct packed {
        logic short_evt;
        logic long_evt;
    } key_evt_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

>>> rtl/kdsl_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdsl_lane
// One key: four-phase debounce machine with a saturating hold counter.
// State advances once per accepted scan tick.
// ----------------------------------------------------------------------------
module kdsl_lane
    import kdsl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick,
    input  logic             active,
    input  logic [DEB_W-1:0] debounce_ticks,
    input  logic [CNT_W-1:0] long_ticks,
    output key_evt_t         evt
);

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_inc;

    assign count_inc = sat_inc(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        evt.short_evt = 1'b0;
        evt.long_evt  = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (active)
                begin
                    count_next = '0;
                    phase_next = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE:
            begin
                if (active)
                begin
                    if (count_inc >= {{(CNT_W-DEB_W){1'b0}}, debounce_ticks})
                    begin
                        count_next = '0;
                        phase_next = PH_PRESSED;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                else
                begin
                    // bounce: back to idle, count left as is
                    phase_next = PH_IDLE;
                end
            end
            PH_PRESSED:
            begin
                if (active)
                begin
                    count_next = count_inc;
                    if (count_inc >= long_ticks)
                    begin
                        evt.long_evt = 1'b1;
                        phase_next   = PH_LONG;
                    end
                end
                else
                begin
                    evt.short_evt = 1'b1;
                    phase_next    = PH_IDLE;
                end
            end
            PH_LONG:
            begin
                if (!active)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/kdsl_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdsl_merge
// Gathers the lane findings into event masks and holds them in an output
// register backed by one skid entry.
// ----------------------------------------------------------------------------
module kdsl_merge
    import kdsl_pkg::*;
#(
    parameter int KEY_COUNT = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  key_evt_t             lane_evt [KEY_COUNT],
    output logic                 skid_full,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIN_W-1:0]     short_events,
    output logic [PIN_W-1:0]     long_events
);

    logic [PIN_W-1:0] short_mask, long_mask;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [PIN_W-1:0] out_short_reg, out_long_reg;
    logic [PIN_W-1:0] skid_short_reg, skid_long_reg;
    logic             pop;
    logic             load_out, load_skid, move_skid;

    // keys beyond the word width have no event bit
    for (genvar i = 0; i < PIN_W; i++)
    begin : g_mask
        if (i < KEY_COUNT)
        begin : g_key
            assign short_mask[i] = lane_evt[i].short_evt;
            assign long_mask[i]  = lane_evt[i].long_evt;
        end
        else
        begin : g_none
            assign short_mask[i] = 1'b0;
            assign long_mask[i]  = 1'b0;
        end
    end

    assign pop       = out_valid_reg && out_ready;
    assign move_skid = skid_valid_reg && (!out_valid_reg || pop);
    assign load_out  = push && !skid_valid_reg && (!out_valid_reg || pop);
    assign load_skid = push && !skid_valid_reg && out_valid_reg && !pop;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (move_skid || load_out)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        if (move_skid)
            skid_valid_next = 1'b0;
        else if (load_skid)
            skid_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move_skid)
        begin
            out_short_reg <= skid_short_reg;
            out_long_reg  <= skid_long_reg;
        end
        else if (load_out)
        begin
            out_short_reg <= short_mask;
            out_long_reg  <= long_mask;
        end
        if (load_skid)
        begin
            skid_short_reg <= short_mask;
            skid_long_reg  <= long_mask;
        end
    end

    assign skid_full    = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign short_events = out_short_reg;
    assign long_events  = out_long_reg;

`ifndef SYNTH
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held while output register empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid word not moved to output on pop");

    a_events_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_short_reg & out_long_reg) == '0))
        else $error("key reported short and long in one word");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !(load_out || load_skid))
        else $error("word taken while skid entry full");
`endif

endmodule

>>> rtl/key_debounce_short_long_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_short_long_press
// Multi-key debouncer: one lane per key runs the debounce / press / long hold
// machine on every scan tick, a merge stage forms the event word.
// ----------------------------------------------------------------------------
//  channel  signals                              direction  width
//  in       in_valid/in_ready, pin_levels        input      8
//  out      out_valid/out_ready, short_events,   output     8 + 8
//           long_events
//  cfg      cfg_we, cfg_index, cfg_data          input      2 / 16
//
//  One scan tick per cycle while in_ready is high; each accepted tick's event word
//  is registered in the output register, or in the skid entry if the output is
//  stalled. All lanes update in parallel in the cycle of acceptance.
//  Reset puts every key in idle with a zero count and loads the register
//  defaults (active low, debounce 2, long 100).
//  A stalled output is covered by one skid entry; ticks stop being taken only
//  when both output register and skid entry are full.
// ----------------------------------------------------------------------------
module key_debounce_short_long_press
    import kdsl_pkg::*;
#(
    parameter int KEY_COUNT = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIN_W-1:0]     pin_levels,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIN_W-1:0]     short_events,
    output logic [PIN_W-1:0]     long_events,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic             active_level_reg;
    logic [DEB_W-1:0] debounce_ticks_reg;
    logic [CNT_W-1:0] long_ticks_reg;
    logic             tick;
    logic             skid_full;
    key_evt_t         lane_evt [KEY_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg   <= 1'b0;
            debounce_ticks_reg <= DEB_W'(2);
            long_ticks_reg     <= CNT_W'(100);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACTIVE_LEVEL:   active_level_reg   <= cfg_data[0];
                REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data[DEB_W-1:0];
                REG_LONG_TICKS:     long_ticks_reg     <= cfg_data[CNT_W-1:0];
                default:            ;
            endcase
        end
    end

    assign in_ready = !skid_full;
    assign tick     = in_valid && in_ready;

    for (genvar k = 0; k < KEY_COUNT; k++)
    begin : g_lane
        logic active;
        if (k < PIN_W)
        begin : g_pin
            assign active = (pin_levels[k] == active_level_reg);
        end
        else
        begin : g_nopin
            // no pin for this key, it always reads released
            assign active = 1'b0;
        end

        kdsl_lane u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .tick           (tick),
            .active         (active),
            .debounce_ticks (debounce_ticks_reg),
            .long_ticks     (long_ticks_reg),
            .evt            (lane_evt[k])
        );
    end

    kdsl_merge #(
        .KEY_COUNT (KEY_COUNT)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (tick),
        .lane_evt     (lane_evt),
        .skid_full    (skid_full),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .short_events (short_events),
        .long_events  (long_events)
    );

endmodule

>>> tb/kdsl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdsl_checker
// Watches the scan, event and register ports of the key debouncer, keeps its
// own per-key phase machines and register copies, and compares each event
// word taken from the block with the oldest predicted one.
// ----------------------------------------------------------------------------
module kdsl_checker
    import kdsl_pkg::*;
#(
    parameter int KEY_COUNT = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [PIN_W-1:0]     pin_levels,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [PIN_W-1:0]     short_events,
    input  logic [PIN_W-1:0]     long_events,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   waiting
);

    typedef struct packed {
        logic [PIN_W-1:0] shorts;
        logic [PIN_W-1:0] longs;
    } event_word_t;

    event_word_t      event_q[$];

    logic             press_level;
    logic [DEB_W-1:0] deb_limit;
    logic [CNT_W-1:0] long_limit;
    phase_t           key_ph  [KEY_COUNT];
    logic [CNT_W-1:0] key_cnt [KEY_COUNT];

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

    // advance every key by one scan tick and queue the event word it gives
    task automatic scan_keys(input logic [PIN_W-1:0] pins);
        event_word_t w;
        logic        on;
        w = '0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            // keys past the pin word never see a press
            on = (k < PIN_W) ? (pins[k] == press_level) : 1'b0;
            case (key_ph[k])
                PH_IDLE:
                begin
                    if (on)
                    begin
                        key_cnt[k] = '0;
                        key_ph[k]  = PH_DEBOUNCE;
                    end
                end
                PH_DEBOUNCE:
                begin
                    if (on)
                    begin
                        key_cnt[k] = count_up(key_cnt[k]);
                        if (key_cnt[k] >= CNT_W'(deb_limit))
                        begin
                            key_cnt[k] = '0;
                            key_ph[k]  = PH_PRESSED;
                        end
                    end
                    else
                    begin
                        key_ph[k] = PH_IDLE;
                    end
                end
                PH_PRESSED:
                begin
                    if (on)
                    begin
                        key_cnt[k] = count_up(key_cnt[k]);
                        if (key_cnt[k] >= long_limit)
                        begin
                            if (k < PIN_W)
                                w.longs[k] = 1'b1;
                            key_ph[k] = PH_LONG;
                        end
                    end
                    else
                    begin
                        if (k < PIN_W)
                            w.shorts[k] = 1'b1;
                        key_ph[k] = PH_IDLE;
                    end
                end
                default:
                begin
                    if (!on)
                        key_ph[k] = PH_IDLE;
                end
            endcase
        end
        event_q.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        event_word_t want;
        if (!rst_n)
        begin
            press_level = 1'b0;
            deb_limit   = DEB_W'(2);
            long_limit  = CNT_W'(100);
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                key_ph[k]  = PH_IDLE;
                key_cnt[k] = '0;
            end
            event_q.delete();
            fail_count = 0;
            waiting    = 0;
        end
        else
        begin
            // a tick taken at this edge still sees the old register values
            if (in_valid && in_ready)
                scan_keys(pin_levels);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ACTIVE_LEVEL:   press_level = cfg_data[0];
                    REG_DEBOUNCE_TICKS: deb_limit   = cfg_data[DEB_W-1:0];
                    REG_LONG_TICKS:     long_limit  = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (event_q.size() == 0)
                begin
                    $display("%0t: event word with none pending: short %h long %h",
                             $time, short_events, long_events);
                    fail_count++;
                end
                else
                begin
                    want = event_q.pop_front();
                    if (short_events !== want.shorts)
                    begin
                        $display("%0t: short_events expected %h actual %h",
                                 $time, want.shorts, short_events);
                        fail_count++;
                    end
                    if (long_events !== want.longs)
                    begin
                        $display("%0t: long_events expected %h actual %h",
                                 $time, want.longs, long_events);
                        fail_count++;
                    end
                end
            end
            waiting = event_q.size();
        end
    end

endmodule

>>> tb/tb_key_debounce_short_long_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_debounce_short_long_press
// Drives scan ticks of raw key levels into the debouncer under several
// register settings: a directed pass over presses, releases, bounces and
// zero thresholds, then keys held and released at random with some noise.
// Both handshakes idle at random; the checker predicts every event word.
// ----------------------------------------------------------------------------
module tb_key_debounce_short_long_press;
    import kdsl_pkg::*;

    localparam int                   KEYS        = 8;
    localparam int                   QUIET_LIMIT = 1000;
    localparam int                   SETTLE      = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [PIN_W-1:0]     pin_levels;
    logic                 out_valid;
    logic                 out_ready;
    logic [PIN_W-1:0]     short_events;
    logic [PIN_W-1:0]     long_events;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int                   fail_count;
    int                   waiting;
    int                   quiet = 0;
    bit                   calm  = 1'b0;

    key_debounce_short_long_press #(.KEY_COUNT(KEYS)) uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pin_levels   (pin_levels),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .short_events (short_events),
        .long_events  (long_events),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    kdsl_checker #(.KEY_COUNT(KEYS)) u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pin_levels   (pin_levels),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .short_events (short_events),
        .long_events  (long_events),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .waiting      (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // event side back-pressure
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 19);

    // ends the run when neither channel moves a word for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("** key_debounce_short_long_press: FAILED **");
            $finish;
        end
    end

    task automatic send_tick(input logic [PIN_W-1:0] pins);
        while (!calm && $urandom_range(99) < 19)
        begin
            in_valid   <= 1'b0;
            pin_levels <= PIN_W'($urandom);
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        pin_levels <= pins;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop sending and let every pending event word come out
    task automatic drain;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (waiting != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] lvl, input logic [CFG_W-1:0] deb,
                              input logic [CFG_W-1:0] lng);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ACTIVE_LEVEL;
        cfg_data  <= lvl;
        @(posedge clk);
        cfg_index <= REG_DEBOUNCE_TICKS;
        cfg_data  <= deb;
        @(posedge clk);
        cfg_index <= REG_LONG_TICKS;
        cfg_data  <= lng;
        @(posedge clk);
        // unused index must not disturb anything
        cfg_index <= REG_SPARE;
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // keys flip their raw level now and then, held in between
    task automatic run_keys(input int ticks, input int flip_span, input int noise_pct);
        logic [PIN_W-1:0] held;
        held = PIN_W'($urandom);
        repeat (ticks)
        begin
            for (int k = 0; k < PIN_W; k++)
                if ($urandom_range(flip_span - 1) == 0)
                    held[k] = ~held[k];
            if ($urandom_range(99) < noise_pct)
                send_tick(PIN_W'($urandom));
            else
                send_tick(held);
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        pin_levels <= '0;
        out_ready  <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_ACTIVE_LEVEL;
        cfg_data   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: active low, debounce 2, long 100
        send_tick(8'hFF);
        repeat (4) send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'hAA);
        send_tick(8'h55);
        send_tick(8'hAA);
        send_tick(8'h55);
        send_tick(8'hFF);
        drain();

        // active high, zero thresholds, junk in the upper data bits
        write_regs(16'h8001, 16'hAB00, 16'h0000);
        send_tick(8'h00);
        repeat (4) send_tick(8'h0F);
        send_tick(8'h00);
        send_tick(8'hF0);
        send_tick(8'h00);
        send_tick(8'hFF);
        send_tick(8'hFF);
        send_tick(8'h00);
        drain();

        write_regs(16'h0000, 16'h0002, 16'd100);
        run_keys(100, 12, 10);
        drain();

        write_regs(16'h0001, 16'h0000, 16'h0000);
        calm = 1'b1;
        run_keys(80, 4, 10);
        calm = 1'b0;
        drain();

        // longest debounce: only keys left alone long enough get pressed
        write_regs(16'hFFFF, 16'h00FF, 16'h0001);
        run_keys(280, 200, 0);
        drain();

        write_regs(16'hFFFE, 16'h0000, 16'hFFFF);
        run_keys(50, 6, 10);
        drain();

        repeat (3)
        begin
            write_regs(CFG_W'($urandom), {8'($urandom), 8'($urandom_range(6))},
                       CFG_W'($urandom_range(12)));
            run_keys(50, 8, 15);
            drain();
        end

        if (fail_count == 0 && waiting == 0)
            $display("** key_debounce_short_long_press: PASSED **");
        else
            $display("** key_debounce_short_long_press: FAILED **");
        $finish;
    end

endmodule
